// ===== hdl/dcpm_pkg.sv =====
// Shared constants, types and mask helper for the don't-care pattern merge table.
package dcpm_pkg;
  localparam int PatternDepth = 1024;
  localparam int Layers       = 8;
  localparam int SsidBits     = 32;
  localparam int PhiShift     = 16;
  localparam logic [31:0] WildcardCode = 32'hFFFF_FFFF;
  localparam int SectorBits   = 16;
  localparam int IdxW  = $clog2(PatternDepth);
  localparam int CntW  = IdxW + 1;
  localparam int LayW  = (Layers > 1) ? $clog2(Layers) : 1;
  localparam int CovW  = 40;
  localparam int DcSumW = 9;

  localparam logic [2:0] CfgDcCounts = 3'd0;
  localparam logic [2:0] CfgStripMask = 3'd1;
  localparam logic [2:0] CfgMaxDc = 3'd2;
  localparam logic [2:0] CfgMaxPat = 3'd3;
  localparam logic [2:0] CfgLayers = 3'd4;

  localparam logic [1:0] OutMerged = 2'd0;
  localparam logic [1:0] OutAdded = 2'd1;
  localparam logic [1:0] OutRejected = 2'd2;

  typedef logic [SsidBits-1:0] ssid_t;

  // Allowed don't-care bits of one layer from its count.
  function automatic ssid_t layer_mask(input logic [3:0] n, input logic strip);
    logic [63:0] m;
    logic [3:0] nx;
    logic [3:0] ny;
    nx = {1'b0, n[3:1]} + {3'd0, n[0]};
    ny = {1'b0, n[3:1]};
    if (strip) m = (64'd1 << n) - 64'd1;
    else m = ((64'd1 << nx) - 64'd1) | (((64'd1 << ny) - 64'd1) << PhiShift);
    return m[SsidBits-1:0];
  endfunction
endpackage

// ===== hdl/dcpm_layer_unit.sv =====
// Shared compare unit: checks one stored layer against the input layer.
module dcpm_layer_unit (
  input  dcpm_pkg::ssid_t t_i,
  input  dcpm_pkg::ssid_t d_i,
  input  dcpm_pkg::ssid_t s_i,
  input  dcpm_pkg::ssid_t allow_i,
  output logic            ok_o,
  output dcpm_pkg::ssid_t newdc_o,
  output logic [5:0]      pop_o
);
  import dcpm_pkg::*;
  ssid_t wild;
  ssid_t diff;
  assign wild = WildcardCode[SsidBits-1:0];
  assign diff = t_i ^ s_i;
  always_comb begin
    if (t_i == wild || s_i == wild) begin
      ok_o = (t_i == s_i);
      newdc_o = d_i;
    end else begin
      ok_o = ((diff & ~allow_i) == '0);
      newdc_o = d_i | diff;
    end
    pop_o = 6'($countones(newdc_o));
  end
endmodule

// ===== hdl/dont_care_pattern_merge_table_top.sv =====
// Top level of the don't-care pattern merge table: sequencer, bank memories, result register.
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one pattern beat: sector, eight ssids,
//   coverage. Output channel (out_valid_o/out_ready_i) returns one beat per pattern:
//   outcome, entry_index, pattern_total. Through the config port the user writes
//   registers by index only while the block is idle; the block does not enforce this.
// Timing:
//   A pattern walks the held entries one layer per cycle through a single compare
//   unit, after each entry's sector is read (StRdE) and checked (StChkE). Entries of
//   other sectors cost only that read and check. A merge then writes back each live
//   layer (StWrM), an add writes all eight layers (StAdd), a rejection costs nothing
//   extra. The block takes one pattern at a time, and the next one can be accepted
//   in the same cycle as the result is taken. in_ready_o is high only when idle and
//   the result register is free or being taken, so a stalled receiver holds the
//   result and blocks the next pattern.
// Reset:
//   Clears the entry count and the config registers to their defaults. The bank
//   memories are not cleared; only entries below the count are ever used.
module dont_care_pattern_merge_table_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] sector_i,
  input  logic [31:0] ssid_layer0_i,
  input  logic [31:0] ssid_layer1_i,
  input  logic [31:0] ssid_layer2_i,
  input  logic [31:0] ssid_layer3_i,
  input  logic [31:0] ssid_layer4_i,
  input  logic [31:0] ssid_layer5_i,
  input  logic [31:0] ssid_layer6_i,
  input  logic [31:0] ssid_layer7_i,
  input  logic [31:0] coverage_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  outcome_o,
  output logic [9:0]  entry_index_o,
  output logic [10:0] pattern_total_o
);
  import dcpm_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRdE  = 3'd1;
  localparam logic [2:0] StChkE = 3'd2;
  localparam logic [2:0] StLay  = 3'd3;
  localparam logic [2:0] StWrM  = 3'd4;
  localparam logic [2:0] StAdd  = 3'd5;

  // config
  logic [31:0] dc_cnt_q;
  logic [7:0]  strip_q;
  logic [8:0]  max_dc_q;
  logic [10:0] max_pat_q;
  logic [3:0]  layers_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_cnt_q <= '0;
      strip_q <= '0;
      max_dc_q <= 9'd256;
      max_pat_q <= 11'd1024;
      layers_q <= 4'd8;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgDcCounts:  dc_cnt_q <= cfg_data_i;
        CfgStripMask: strip_q <= cfg_data_i[7:0];
        CfgMaxDc:     max_dc_q <= cfg_data_i[8:0];
        CfgMaxPat:    max_pat_q <= cfg_data_i[10:0];
        CfgLayers:    layers_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // memories
  logic [SectorBits-1:0] sec_mem [PatternDepth];
  logic [CovW-1:0]       cov_mem [PatternDepth];
  ssid_t                 ssid_mem [PatternDepth*Layers];
  ssid_t                 dc_mem [PatternDepth*Layers];
  ssid_t                 newdc_q [Layers];

  logic [2:0] st_q, st_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] e_q, e_d;
  logic [LayW-1:0] l_q, l_d;
  logic [LayW:0]   nl;
  logic [9:0]      total_q, total_d;
  logic [SectorBits-1:0] sec_q;
  ssid_t ss_q [Layers];
  logic [31:0] cov_q;
  logic [SectorBits-1:0] sec_rd_q;
  logic [CovW-1:0] cov_rd_q;
  ssid_t t_rd_q, d_rd_q;
  logic ovalid_q, ovalid_d;
  logic [1:0] outc_q, outc_d;
  logic [9:0] oidx_q, oidx_d;
  logic [10:0] otot_q, otot_d;
  logic [CntW-1:0] limit;
  logic [IdxW+LayW-1:0] addr;
  logic [IdxW+LayW-1:0] rd_addr;
  logic [LayW-1:0] rd_l;
  logic u_ok;
  ssid_t u_newdc;
  logic [5:0] u_pop;
  logic [9:0] tot_next;
  logic last_e;
  logic [CovW:0] cov_sum;
  logic lay_fail;
  logic lay_last;
  logic next_e;
  logic scan_end;

  always_comb begin
    if (layers_q == 4'd0) nl = (LayW+1)'(1);
    else if (layers_q > 4'(Layers)) nl = (LayW+1)'(Layers);
    else nl = (LayW+1)'(layers_q);
    limit = (max_pat_q > 11'(PatternDepth)) ? CntW'(PatternDepth) : CntW'(max_pat_q);
  end

  assign addr = {e_q, l_q};
  // layer to fetch next: while checking a layer, prefetch the following one
  assign rd_l = (st_q == StLay) ? l_q + LayW'(1) : '0;
  assign rd_addr = {e_q, rd_l};

  dcpm_layer_unit u_layer (
    .t_i(t_rd_q), .d_i(d_rd_q), .s_i(ss_q[l_q]),
    .allow_i(layer_mask(dc_cnt_q[{l_q, 2'b00} +: 4], strip_q[l_q])),
    .ok_o(u_ok), .newdc_o(u_newdc), .pop_o(u_pop)
  );

  assign tot_next = total_q + 10'(u_pop);
  assign last_e = (CntW'(e_q) + CntW'(1) >= count_q);
  assign cov_sum = {1'b0, cov_rd_q} + (CovW+1)'(cov_q);
  assign in_ready_o = (st_q == StIdle) && (!ovalid_q || out_ready_i);
  assign lay_fail = !u_ok || (tot_next > {1'b0, max_dc_q});
  assign lay_last = ((LayW+1)'(l_q) + (LayW+1)'(1) >= nl);

  always_ff @(posedge clk_i) begin
    sec_rd_q <= sec_mem[e_q];
    cov_rd_q <= cov_mem[e_q];
    t_rd_q <= ssid_mem[rd_addr];
    d_rd_q <= dc_mem[rd_addr];
    if (st_q == StLay) newdc_q[l_q] <= u_newdc;
    if (st_q == StWrM) begin
      dc_mem[addr] <= newdc_q[l_q];
      if (l_q == '0) cov_mem[e_q] <= cov_sum[CovW] ? {CovW{1'b1}} : cov_sum[CovW-1:0];
    end
    if (st_q == StAdd) begin
      ssid_mem[addr] <= ss_q[l_q];
      dc_mem[addr] <= '0;
      if (l_q == '0) begin
        sec_mem[e_q] <= sec_q;
        cov_mem[e_q] <= {8'd0, cov_q};
      end
    end
    if (in_valid_i && in_ready_o) begin
      sec_q <= sector_i[SectorBits-1:0];
      ss_q[0] <= ssid_layer0_i[SsidBits-1:0];
      ss_q[1] <= ssid_layer1_i[SsidBits-1:0];
      ss_q[2] <= ssid_layer2_i[SsidBits-1:0];
      ss_q[3] <= ssid_layer3_i[SsidBits-1:0];
      ss_q[4] <= ssid_layer4_i[SsidBits-1:0];
      ss_q[5] <= ssid_layer5_i[SsidBits-1:0];
      ss_q[6] <= ssid_layer6_i[SsidBits-1:0];
      ss_q[7] <= ssid_layer7_i[SsidBits-1:0];
      cov_q <= coverage_i;
    end
  end

  always_comb begin
    st_d = st_q;
    count_d = count_q;
    e_d = e_q;
    l_d = l_q;
    total_d = total_q;
    ovalid_d = ovalid_q;
    outc_d = outc_q;
    oidx_d = oidx_q;
    otot_d = otot_q;
    next_e = 1'b0;
    scan_end = 1'b0;
    if (out_valid_o && out_ready_i) ovalid_d = 1'b0;
    case (st_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          st_d = StRdE;
          e_d = '0;
          l_d = '0;
          total_d = '0;
        end
      end
      StRdE: begin
        if (count_q == '0) scan_end = 1'b1;
        else st_d = StChkE;
      end
      StChkE: begin
        // sector read is registered; entry data of layer 0 is now valid
        l_d = '0;
        total_d = '0;
        if (sec_rd_q != sec_q) next_e = 1'b1;
        else st_d = StLay;
      end
      StLay: begin
        if (lay_fail) next_e = 1'b1;
        else if (lay_last) begin
          st_d = StWrM;
          l_d = '0;
        end else begin
          total_d = tot_next;
          l_d = l_q + LayW'(1);
        end
      end
      StWrM: begin
        if (lay_last) begin
          st_d = StIdle;
          ovalid_d = 1'b1;
          outc_d = OutMerged;
          oidx_d = 10'(e_q);
          otot_d = 11'(count_q);
        end else l_d = l_q + LayW'(1);
      end
      StAdd: begin
        if (l_q == LayW'(Layers - 1)) begin
          st_d = StIdle;
          count_d = count_q + CntW'(1);
          ovalid_d = 1'b1;
          outc_d = OutAdded;
          oidx_d = 10'(e_q);
          otot_d = 11'(count_q + CntW'(1));
        end else l_d = l_q + LayW'(1);
      end
      default: st_d = StIdle;
    endcase
    if (next_e) begin
      l_d = '0;
      total_d = '0;
      if (last_e) scan_end = 1'b1;
      else begin
        e_d = e_q + IdxW'(1);
        st_d = StRdE;
      end
    end
    // no entry took the pattern: add while there is room, else reject
    if (scan_end) begin
      if (count_q < limit) begin
        st_d = StAdd;
        e_d = count_q[IdxW-1:0];
        l_d = '0;
      end else begin
        st_d = StIdle;
        ovalid_d = 1'b1;
        outc_d = OutRejected;
        oidx_d = '0;
        otot_d = 11'(count_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      count_q <= '0;
      e_q <= '0;
      l_q <= '0;
      total_q <= '0;
      ovalid_q <= 1'b0;
      outc_q <= OutMerged;
      oidx_q <= '0;
      otot_q <= '0;
    end else begin
      st_q <= st_d;
      count_q <= count_d;
      e_q <= e_d;
      l_q <= l_d;
      total_q <= total_d;
      ovalid_q <= ovalid_d;
      outc_q <= outc_d;
      oidx_q <= oidx_d;
      otot_q <= otot_d;
    end
  end

  assign out_valid_o = ovalid_q;
  assign outcome_o = outc_q;
  assign entry_index_o = oidx_q;
  assign pattern_total_o = otot_q;
endmodule

// ===== hdl/dcpm_checker.sv =====
// Port-level checker for the pattern merge table, bound to the top level.
module dcpm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  outcome_o,
  input logic [9:0]  entry_index_o,
  input logic [10:0] pattern_total_o
);
  import dcpm_pkg::*;
  a_no_accept_while_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o) else $error("accept with result held");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("ready right after accept");
  a_reject_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && outcome_o == OutRejected) |-> entry_index_o == '0)
    else $error("rejected beat with index");
  a_outcome_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (outcome_o != 2'd3 && pattern_total_o <= 11'(PatternDepth)))
    else $error("bad result beat");
endmodule

bind dont_care_pattern_merge_table_top dcpm_checker u_dcpm_checker (.*);

// ===== tb/testbench.sv =====
// Testbench for the don't-care pattern merge table: predictor, driver, monitor and phases.
module testbench;
  import dcpm_pkg::*;

  typedef struct packed {
    logic [15:0] sector;
    logic [7:0][31:0] ssid;
    logic [31:0] coverage;
  } beat_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [9:0]  entry_index;
    logic [10:0] pattern_total;
  } verdict_t;

  localparam logic [39:0] CovSat = 40'hFF_FFFF_FFFF;
  localparam logic [31:0] Wild   = WildcardCode;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  beat_t beat = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] outcome;
  logic [9:0] entry_index;
  logic [10:0] pattern_total;

  dont_care_pattern_merge_table_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .sector_i(beat.sector),
    .ssid_layer0_i(beat.ssid[0]), .ssid_layer1_i(beat.ssid[1]),
    .ssid_layer2_i(beat.ssid[2]), .ssid_layer3_i(beat.ssid[3]),
    .ssid_layer4_i(beat.ssid[4]), .ssid_layer5_i(beat.ssid[5]),
    .ssid_layer6_i(beat.ssid[6]), .ssid_layer7_i(beat.ssid[7]),
    .coverage_i(beat.coverage),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .outcome_o(outcome), .entry_index_o(entry_index), .pattern_total_o(pattern_total)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow of the registers and the bank
  logic [31:0] sh_dc_counts = 32'd0;
  logic [7:0]  sh_strip = 8'd0;
  logic [8:0]  sh_max_dc = 9'd256;
  logic [10:0] sh_max_pat = 11'd1024;
  logic [3:0]  sh_layers = 4'd8;
  logic [15:0] bank_sector [PatternDepth];
  logic [31:0] bank_ssid [PatternDepth][Layers];
  logic [31:0] bank_dc [PatternDepth][Layers];
  logic [39:0] bank_cov [PatternDepth];
  int unsigned bank_count = 0;

  beat_t pending_beats[$];
  verdict_t verdicts_due[$];
  int unsigned failures = 0;
  int unsigned n_merged = 0, n_added = 0, n_rejected = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  function automatic logic [31:0] dc_allow(int l);
    int n, nx, ny;
    logic [63:0] m;
    n = (sh_dc_counts >> (4 * l)) & 15;
    nx = n - n / 2;
    ny = n / 2;
    if (sh_strip[l]) m = (64'd1 << n) - 1;
    else m = ((64'd1 << nx) - 1) | (((64'd1 << ny) - 1) << PhiShift);
    return m[31:0];
  endfunction

  function automatic int live_layers();
    if (sh_layers == 0) return 1;
    if (sh_layers > Layers) return Layers;
    return sh_layers;
  endfunction

  task automatic queue_beat(input beat_t p);
    pending_beats.insert(pending_beats.size(), p);
  endtask

  task automatic merge_or_add(input beat_t p);
    logic [31:0] dc_next [Layers];
    logic [31:0] t, diff;
    logic [40:0] sum;
    int nl, total, limit;
    bit ok;
    verdict_t v;
    nl = live_layers();
    for (int e = 0; e < bank_count; e++) begin
      if (bank_sector[e] != p.sector) continue;
      ok = 1'b1;
      total = 0;
      for (int l = 0; l < nl && ok; l++) begin
        t = bank_ssid[e][l];
        if (t == Wild || p.ssid[l] == Wild) begin
          if (t != p.ssid[l]) ok = 1'b0;
          dc_next[l] = bank_dc[e][l];
        end else begin
          diff = t ^ p.ssid[l];
          if ((diff & ~dc_allow(l)) != 0) ok = 1'b0;
          dc_next[l] = bank_dc[e][l] | diff;
        end
        if (ok) begin
          total += $countones(dc_next[l]);
          if (total > sh_max_dc) ok = 1'b0;
        end
      end
      if (ok) begin
        for (int l = 0; l < nl; l++) bank_dc[e][l] = dc_next[l];
        sum = bank_cov[e] + p.coverage;
        bank_cov[e] = (sum > CovSat) ? CovSat : sum[39:0];
        v.outcome = OutMerged;
        v.entry_index = e[9:0];
        v.pattern_total = bank_count[10:0];
        verdicts_due.insert(verdicts_due.size(), v);
        n_merged++;
        return;
      end
    end
    limit = (sh_max_pat > PatternDepth) ? PatternDepth : sh_max_pat;
    if (bank_count < limit) begin
      bank_sector[bank_count] = p.sector;
      for (int l = 0; l < Layers; l++) begin
        bank_ssid[bank_count][l] = p.ssid[l];
        bank_dc[bank_count][l] = '0;
      end
      bank_cov[bank_count] = {8'd0, p.coverage};
      v.outcome = OutAdded;
      v.entry_index = bank_count[9:0];
      bank_count++;
      v.pattern_total = bank_count[10:0];
      n_added++;
    end else begin
      v.outcome = OutRejected;
      v.entry_index = '0;
      v.pattern_total = bank_count[10:0];
      n_rejected++;
    end
    verdicts_due.insert(verdicts_due.size(), v);
  endtask

  // sender
  int unsigned send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) merge_or_add(beat);
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          beat <= pending_beats.pop_front();
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 7);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          $error("result beat with nothing expected");
          failures++;
        end else begin
          want = verdicts_due.pop_front();
          if (outcome !== want.outcome) begin
            $error("outcome: expected %0d, got %0d", want.outcome, outcome);
            failures++;
          end
          if (entry_index !== want.entry_index) begin
            $error("entry_index: expected %0d, got %0d", want.entry_index, entry_index);
            failures++;
          end
          if (pattern_total !== want.pattern_total) begin
            $error("pattern_total: expected %0d, got %0d", want.pattern_total, pattern_total);
            failures++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= 300;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    case (idx)
      CfgDcCounts:  sh_dc_counts = val;
      CfgStripMask: sh_strip = val[7:0];
      CfgMaxDc:     sh_max_dc = val[8:0];
      CfgMaxPat:    sh_max_pat = val[10:0];
      CfgLayers:    sh_layers = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [31:0] dc, input logic [7:0] strip,
                          input logic [8:0] maxdc, input logic [10:0] maxpat,
                          input logic [3:0] lay);
    reg_write(CfgDcCounts, dc);
    reg_write(CfgStripMask, {24'd0, strip});
    reg_write(CfgMaxDc, {23'd0, maxdc});
    reg_write(CfgMaxPat, {21'd0, maxpat});
    reg_write(CfgLayers, {28'd0, lay});
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || in_valid || verdicts_due.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic beat_t noise_pattern();
    beat_t p;
    p.sector = 16'($urandom);
    for (int l = 0; l < Layers; l++) p.ssid[l] = ($urandom_range(0, 9) == 0) ? Wild : $urandom;
    p.coverage = $urandom;
    return p;
  endfunction

  // random phase: well-formed neighbors of a few seeds, plus broken ones and noise
  task automatic random_phase(input int count);
    beat_t seeds[6];
    beat_t p;
    int k, l, b;
    logic [31:0] am;
    for (int s = 0; s < 6; s++) begin
      seeds[s] = noise_pattern();
      seeds[s].sector = 16'($urandom_range(0, 3) * 32'h5555);
    end
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 19);
      if (k < 3) begin
        p = noise_pattern();
      end else begin
        p = seeds[$urandom_range(0, 5)];
        p.coverage = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom;
        for (int m = 0; m < Layers; m++)
          if (p.ssid[m] != Wild) p.ssid[m] ^= $urandom & dc_allow(m);
        if (k < 6) begin
          l = $urandom_range(0, live_layers() - 1);
          b = $urandom_range(0, 31);
          am = dc_allow(l);
          if (p.ssid[l] == Wild) p.ssid[l] = $urandom;
          else if (!am[b]) p.ssid[l][b] = ~p.ssid[l][b];
          else p.ssid[l] = Wild;
        end
      end
      queue_beat(p);
    end
  endtask

  initial begin
    beat_t p;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset settings: exact matches only
    p = '0;
    queue_beat(p);
    queue_beat(p);                              // exact repeat merges
    p.ssid = '1;
    p.sector = 16'hFFFF;
    p.coverage = 32'hFFFF_FFFF;
    queue_beat(p);
    queue_beat(p);                              // wildcard meets wildcard
    p.ssid[3] = 32'h0;
    queue_beat(p);                              // wildcard meets value: new entry
    p = '0;
    p.ssid[0] = 32'h1;
    queue_beat(p);                              // one bit off, no allowance
    p.sector = 16'h0001;
    p.ssid[0] = 32'h0;
    queue_beat(p);                              // other sector
    drain();

    // widest masks, strip everywhere
    set_regs(32'hFFFF_FFFF, 8'hFF, 9'd256, 11'd1024, 4'd8);
    p = '0;
    p.sector = 16'h0002;
    queue_beat(p);
    p.ssid = {8{32'h0000_7FFF}};
    queue_beat(p);                              // merges within allowance
    p.ssid[7] = 32'h8000_0000;
    queue_beat(p);                              // outside allowance
    p.ssid[7] = Wild;
    queue_beat(p);
    drain();

    // pixel split masks, tight total, fewer layers
    set_regs(32'h3333_3333, 8'h00, 9'd3, 11'd1024, 4'd4);
    p = '0;
    p.sector = 16'h0003;
    queue_beat(p);
    p.ssid[0] = 32'h0001_0003;
    queue_beat(p);                              // x2 + y1 bits, total 3
    p.ssid[1] = 32'h0000_0001;
    queue_beat(p);                              // total would reach 4
    p.ssid[1] = 32'h0;
    p.ssid[6] = 32'hDEAD_BEEF;
    queue_beat(p);                              // layer not compared
    drain();

    // zero total, one layer, ignored register index
    set_regs(32'h5555_5555, 8'hAA, 9'd0, 11'd1024, 4'd0);
    reg_write(3'd7, 32'hFFFF_FFFF);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    p = '0;
    p.sector = 16'h0004;
    queue_beat(p);
    queue_beat(p);
    p.ssid[0] = 32'h1;
    queue_beat(p);
    random_phase(60);
    drain();

    // bank full: merges still allowed, adds rejected
    set_regs(32'h2222_2222, 8'h0F, 9'd40, 11'd0, 4'd15);
    random_phase(60);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      set_regs($urandom, 8'($urandom), 9'($urandom_range(0, 256)),
               (ph == 2) ? 11'd1024 : 11'(bank_count + $urandom_range(0, 40)),
               4'($urandom_range(0, 15)));
      if (ph == 3) hold_req = 1'b1;
      random_phase(75);
      drain();
    end

    quiet = 1'b1;
    set_regs(32'h4444_4444, 8'h5A, 9'd256, 11'd1024, 4'd8);
    random_phase(50);
    drain();

    $display("Patterns checked: %0d merged, %0d added, %0d rejected; bank holds %0d entries.",
             n_merged, n_added, n_rejected, bank_count);
    $display("Settings swept: mask widths, strip and pixel layers, totals, bank limits, layers.");
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("Timeout waiting for results");
    $display("Test completed with failures");
    $finish;
  end
endmodule
